/* rtl/assert_macros.svh */
// Assertion helpers, included by the back part.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FSE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FSE_ASSERT_NEVER(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define FSE_ASSERT(label, clk, rst_n, prop, msg)
`define FSE_ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif
`endif

/* rtl/fse_pkg.sv */
package fse_pkg;

  localparam int unsigned MaxHarm = 16;
  localparam int unsigned IdxW = 4;
  localparam int unsigned DegW = 5;

  localparam logic [1:0] CmdWrite = 2'd0;
  localparam logic [1:0] CmdRead = 2'd1;
  localparam logic [1:0] CmdEval = 2'd2;

  localparam logic [1:0] RegDegree = 2'd0;
  localparam logic [1:0] RegInvPeriod = 2'd1;

  localparam logic signed [31:0] Sc1 = 32'sd1686629713;
  localparam logic signed [31:0] Sc3 = -32'sd693598668;
  localparam logic signed [31:0] Sc5 = 32'sd85569306;
  localparam logic signed [31:0] Sc7 = -32'sd5026995;
  localparam logic signed [31:0] Sc9 = 32'sd172272;

  typedef struct packed {
    logic [1:0]         command;
    logic [3:0]         coeff_index;
    logic signed [31:0] coeff_cos_in;
    logic signed [31:0] coeff_sin_in;
    logic signed [31:0] sample_point;
  } req_t;

  typedef struct packed {
    logic signed [31:0] series_value;
    logic signed [31:0] coeff_cos_out;
    logic signed [31:0] coeff_sin_out;
    logic               index_error;
  } rsp_t;

  // Classified request handed from the front part to the evaluator.
  typedef struct packed {
    logic [31:0]     frac;
    logic [DegW-1:0] degree;
  } job_t;

endpackage

/* rtl/fse_front.sv */
// Front part: executes table commands directly and queues evaluate jobs.
module fse_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  fse_pkg::req_t       req_i,
  input  logic [4:0]          degree_i,
  input  logic [31:0]         inv_period_i,
  input  logic                job_pop_i,
  output logic                job_valid_o,
  output fse_pkg::job_t       job_o,
  output logic                rsp_valid_o,
  output fse_pkg::rsp_t       rsp_o,
  output logic                busy_o,
  input  logic [3:0]          rd_idx_i,
  output logic signed [31:0]  rd_cos_o,
  output logic signed [31:0]  rd_sin_o
);

  logic signed [31:0] cos_tab_q [fse_pkg::MaxHarm];
  logic signed [31:0] sin_tab_q [fse_pkg::MaxHarm];
  logic [fse_pkg::DegW-1:0] deg_eff;
  logic idx_bad;
  logic job_pend_q;
  logic mul_pend_q;
  logic [fse_pkg::DegW-1:0] mul_deg_q;
  logic signed [31:0] mul_x_q;
  logic [31:0] mul_p_q;
  fse_pkg::job_t job_q;
  logic rsp_valid_q;
  fse_pkg::rsp_t rsp_d;
  fse_pkg::rsp_t rsp_q;

  // Effective degree clamped to the range 1 to MaxHarm.
  assign deg_eff = (degree_i == '0) ? 5'd1 :
                   (degree_i > 5'(fse_pkg::MaxHarm)) ? 5'(fse_pkg::MaxHarm) : degree_i;
  assign idx_bad = {1'b0, req_i.coeff_index} >= deg_eff;

  // Coefficient table, reset to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fse_pkg::MaxHarm; i++) begin
        cos_tab_q[i] <= '0;
        sin_tab_q[i] <= '0;
      end
    end else if (req_valid_i && req_i.command == fse_pkg::CmdWrite && !idx_bad) begin
      cos_tab_q[req_i.coeff_index] <= req_i.coeff_cos_in;
      sin_tab_q[req_i.coeff_index] <= req_i.coeff_sin_in;
    end
  end

  assign rd_cos_o = cos_tab_q[rd_idx_i];
  assign rd_sin_o = sin_tab_q[rd_idx_i];

  // Result of a table command; other commands leave every field at zero.
  always_comb begin
    rsp_d = '0;
    if (req_valid_i) begin
      if (req_i.command == fse_pkg::CmdWrite || req_i.command == fse_pkg::CmdRead) begin
        rsp_d.index_error = idx_bad;
        if (req_i.command == fse_pkg::CmdRead && !idx_bad) begin
          rsp_d.coeff_cos_out = cos_tab_q[req_i.coeff_index];
          rsp_d.coeff_sin_out = sin_tab_q[req_i.coeff_index];
        end
      end
    end
  end

  // Table responses and the phase multiply feeding the one-entry job queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
      mul_pend_q <= 1'b0;
      job_pend_q <= 1'b0;
    end else begin
      rsp_valid_q <= req_valid_i && req_i.command != fse_pkg::CmdEval;
      mul_pend_q <= req_valid_i && req_i.command == fse_pkg::CmdEval;
      if (mul_pend_q) job_pend_q <= 1'b1;
      else if (job_pop_i) job_pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (req_valid_i) begin
      mul_x_q <= req_i.sample_point;
      mul_deg_q <= deg_eff;
      mul_p_q <= inv_period_i;
    end
    if (mul_pend_q) begin
      job_q.frac <= 32'(mul_x_q * $signed({1'b0, mul_p_q}));
      job_q.degree <= mul_deg_q;
    end
  end

  assign job_valid_o = job_pend_q;
  assign job_o = job_q;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o = rsp_q;
  assign busy_o = rsp_valid_q || mul_pend_q || job_pend_q;

endmodule

/* rtl/fse_sine.sv */
// Pipelined quarter-wave sine: one phase in per cycle.
module fse_sine (
  input  logic               clk_i,
  input  logic [31:0]        ang_i,
  output logic signed [31:0] sin_o
);

  localparam int unsigned Stages = 7;
  logic signed [31:0] z_q [Stages];
  logic signed [31:0] z2_q [Stages];
  logic signed [31:0] t_q [Stages];
  logic neg_q [Stages];
  logic signed [63:0] prod;
  logic signed [63:0] fin;
  logic signed [33:0] sres;

  always_comb begin
    prod = 64'(t_q[5]) * 64'(z_q[5]);
    fin  = prod >>> 30;
    if (fin < 0) sres = '0;
    else if (fin > 64'sd1073741824) sres = 34'sd1073741824;
    else sres = 34'(fin);
  end

  // Stage 0 folds the quadrant, 1 squares, 2 to 5 run Horner, 6 scales and signs.
  always_ff @(posedge clk_i) begin
    z_q[0] <= ang_i[30] ? 32'(32'sd1073741824 - $signed({2'b0, ang_i[29:0]}))
                        : $signed({2'b0, ang_i[29:0]});
    neg_q[0] <= ang_i[31];
    z2_q[0] <= '0;
    t_q[0] <= fse_pkg::Sc9;
    z2_q[1] <= 32'((64'(z_q[0]) * 64'(z_q[0])) >>> 30);
    z_q[1] <= z_q[0];
    neg_q[1] <= neg_q[0];
    t_q[1] <= fse_pkg::Sc9;
    for (int s = 2; s < 6; s++) begin
      z_q[s] <= z_q[s-1];
      z2_q[s] <= z2_q[s-1];
      neg_q[s] <= neg_q[s-1];
    end
    t_q[2] <= fse_pkg::Sc7 + 32'((64'(t_q[1]) * 64'(z2_q[1])) >>> 30);
    t_q[3] <= fse_pkg::Sc5 + 32'((64'(t_q[2]) * 64'(z2_q[2])) >>> 30);
    t_q[4] <= fse_pkg::Sc3 + 32'((64'(t_q[3]) * 64'(z2_q[3])) >>> 30);
    t_q[5] <= fse_pkg::Sc1 + 32'((64'(t_q[4]) * 64'(z2_q[4])) >>> 30);
    z_q[6] <= '0;
    z2_q[6] <= '0;
    t_q[6] <= neg_q[5] ? -32'(sres) : 32'(sres);
    neg_q[6] <= neg_q[5];
  end

  assign sin_o = t_q[6];

endmodule

/* rtl/fse_back.sv */
// Back part: walks the harmonics, sine and cosine units in parallel.
module fse_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  fse_pkg::job_t      job_i,
  output logic               job_pop_o,
  output logic [3:0]         rd_idx_o,
  input  logic signed [31:0] rd_cos_i,
  input  logic signed [31:0] rd_sin_i,
  output logic               rsp_valid_o,
  output fse_pkg::rsp_t      rsp_o,
  output logic               busy_o
);
  `include "assert_macros.svh"

  localparam int unsigned SinLat = 7;

  typedef enum logic [1:0] {StIdle, StIssue, StDrain, StDone} state_e;
  state_e state_q;
  logic [4:0] issue_q;
  logic [4:0] deg_q;
  logic [31:0] frac_q;
  logic [31:0] ang_q;
  logic [SinLat-1:0] vld_q;
  logic signed [31:0] ca_q [SinLat];
  logic signed [31:0] cb_q [SinLat];
  logic signed [31:0] sn, cs;
  logic signed [63:0] pa_q, pb_q;
  logic pv_q;
  logic signed [63:0] acc_q;
  logic signed [63:0] quo;
  logic rsp_valid_q;
  fse_pkg::rsp_t rsp_d;
  fse_pkg::rsp_t rsp_q;

  fse_sine u_sin (.clk_i(clk_i), .ang_i(ang_q), .sin_o(sn));
  fse_sine u_cos (.clk_i(clk_i), .ang_i(ang_q + 32'h4000_0000), .sin_o(cs));

  assign rd_idx_o = issue_q[3:0];
  assign job_pop_o = (state_q == StIdle) && job_valid_i;

  // Truncate toward zero by the Q17 scale, then saturate to 32 bits.
  always_comb begin
    quo = (acc_q < 0) ? -((-acc_q) >>> 17) : (acc_q >>> 17);
    rsp_d = '0;
    if (quo > 64'sd2147483647) rsp_d.series_value = 32'h7FFF_FFFF;
    else if (quo < -64'sd2147483648) rsp_d.series_value = 32'h8000_0000;
    else rsp_d.series_value = 32'(quo);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      vld_q <= '0;
      pv_q <= 1'b0;
      rsp_valid_q <= 1'b0;
      issue_q <= '0;
    end else begin
      rsp_valid_q <= state_q == StDone;
      pv_q <= vld_q[SinLat-1];
      vld_q <= {vld_q[SinLat-2:0], state_q == StIssue && issue_q != 5'd0};
      case (state_q)
        StIdle: begin
          if (job_valid_i) begin
            issue_q <= 5'd0;
            state_q <= StIssue;
          end
        end
        StIssue: begin
          if (issue_q == deg_q - 5'd1) state_q <= StDrain;
          else issue_q <= issue_q + 5'd1;
        end
        StDrain: begin
          if (vld_q == '0 && !pv_q) state_q <= StDone;
        end
        StDone: begin
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Datapath: phase step, coefficient delay line, products, accumulator.
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      frac_q <= job_i.frac;
      deg_q <= job_i.degree;
      ang_q <= '0;
    end else if (state_q == StIssue) begin
      ang_q <= ang_q + frac_q;
    end
    ca_q[0] <= rd_cos_i;
    cb_q[0] <= rd_sin_i;
    for (int s = 1; s < SinLat; s++) begin
      ca_q[s] <= ca_q[s-1];
      cb_q[s] <= cb_q[s-1];
    end
    pa_q <= (64'(ca_q[SinLat-1]) * 64'(cs)) >>> 29;
    pb_q <= (64'(cb_q[SinLat-1]) * 64'(sn)) >>> 29;
    if (state_q == StIssue && issue_q == 5'd0) acc_q <= 64'(rd_cos_i);
    else if (pv_q) acc_q <= acc_q + pa_q + pb_q;
    rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o = rsp_q;
  assign busy_o = state_q != StIdle || rsp_valid_q;

  `FSE_ASSERT(a_pop_idle, clk_i, rst_ni, job_pop_o |=> state_q == StIssue, "pop without issue")
  `FSE_ASSERT(a_issue_range, clk_i, rst_ni, state_q == StIssue |-> issue_q < deg_q, "index overrun")
  `FSE_ASSERT(a_done_drained, clk_i, rst_ni, state_q == StDone |-> vld_q == '0, "done early")
endmodule

/* rtl/fourier_series_evaluator_top.sv */
// Truncated Fourier series evaluator.
// Requests enter on start with req_i while busy is low; one request is
// taken at a time. Commands: write a coefficient pair, read a pair back, or
// evaluate the series at a sample point. Every request gives exactly one
// result on rsp_o, marked by done_o for a single cycle; the receiver cannot
// stall and must take it then.
// Write and read results sit on rsp_o in the cycle right after the request
// edge. Evaluate first multiplies the sample point by the inverse period
// into a phase, hands the job over to the back part, then issues one
// harmonic per cycle through the pipelined sine and cosine units; the
// products are registered, accumulated, scaled and saturated to the result.
// busy stays high through the result cycle, so the next request can be taken
// at the edge after the result edge.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 degree,
// 1 inverse period). Write only while idle; the block does not enforce this.
// Reset clears the coefficient table, sets degree 1 and inverse period 1.0.
module fourier_series_evaluator_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  fse_pkg::req_t  req_i,
  output logic           done_o,
  output fse_pkg::rsp_t  rsp_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [31:0]    cfg_data_i
);

  logic [4:0] degree_q;
  logic [31:0] inv_period_q;
  logic job_valid, job_pop, front_busy, back_busy;
  fse_pkg::job_t job;
  logic f_valid, b_valid;
  fse_pkg::rsp_t f_rsp, b_rsp;
  logic [3:0] rd_idx;
  logic signed [31:0] rd_cos, rd_sin;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= 5'd1;
      inv_period_q <= 32'd65536;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == fse_pkg::RegDegree) degree_q <= cfg_data_i[4:0];
      if (cfg_idx_i == fse_pkg::RegInvPeriod) inv_period_q <= cfg_data_i;
    end
  end

  fse_front u_front (
    .clk_i, .rst_ni,
    .req_valid_i(start && !busy), .req_i,
    .degree_i(degree_q), .inv_period_i(inv_period_q),
    .job_pop_i(job_pop), .job_valid_o(job_valid), .job_o(job),
    .rsp_valid_o(f_valid), .rsp_o(f_rsp), .busy_o(front_busy),
    .rd_idx_i(rd_idx), .rd_cos_o(rd_cos), .rd_sin_o(rd_sin)
  );

  fse_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(job_valid), .job_i(job), .job_pop_o(job_pop),
    .rd_idx_o(rd_idx), .rd_cos_i(rd_cos), .rd_sin_i(rd_sin),
    .rsp_valid_o(b_valid), .rsp_o(b_rsp), .busy_o(back_busy)
  );

  assign busy = front_busy || back_busy;
  assign done_o = f_valid || b_valid;
  assign rsp_o = f_valid ? f_rsp : b_rsp;

endmodule
